/* design/fvn_pkg.sv */
`default_nettype none

package fvn_pkg;

  localparam int PIX_W  = 12;
  localparam int CNT_W  = 4;
  localparam int FREQ_W = 32;
  localparam int AMP_W  = 32;
  localparam int LAC_W  = 20;
  localparam int PERS_W = 17;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int COORD_BITS_DEF  = 12;
  localparam int CELL_LAT        = 10;

  localparam logic [CNT_W-1:0]  RST_OCTAVES = 4'd4;
  localparam logic [FREQ_W-1:0] RST_FREQ    = 32'd838861;
  localparam logic [AMP_W-1:0]  RST_AMP     = 32'd65536;
  localparam logic [LAC_W-1:0]  RST_LAC     = 20'd131072;
  localparam logic [PERS_W-1:0] RST_PERS    = 17'd32768;

  localparam logic [31:0] HASH_KX  = 32'd73856093;
  localparam logic [31:0] HASH_KY  = 32'd19349663;
  localparam logic [31:0] HASH_M1  = 32'd15731;
  localparam logic [31:0] HASH_A1  = 32'd789221;
  localparam logic [31:0] HASH_A2  = 32'd1376312589;
  localparam logic [17:0] SMOOTH_3 = 18'd196608;

  typedef enum logic [IDX_W-1:0] {
    REG_OCTAVES = 3'd0,
    REG_FREQ    = 3'd1,
    REG_AMP     = 3'd2,
    REG_LAC     = 3'd3,
    REG_PERS    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [FREQ_W-1:0] freq;
    logic [AMP_W-1:0]  amp;
    logic [31:0]       acc;
    logic              flag;
  } lane_t;

  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  count;
    logic [LAC_W-1:0]  lacunarity;
    logic [PERS_W-1:0] persistence;
  } ctl_t;

  // {clip, value}
  function automatic logic [32:0] sat32(input logic signed [35:0] v);
    logic [32:0] r;
    if (v > 36'sd2147483647) begin
      r = {1'b1, 32'h7fffffff};
    end else if (v < -36'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/fvn_if.sv */
`default_nettype none

interface fvn_in_if;
  import fvn_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface fvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height_value;
  logic               saturated;
  modport source (output valid, height_value, saturated, input ready);
  modport sink   (input valid, height_value, saturated, output ready);
endinterface

interface fvn_cfg_if;
  import fvn_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/fractal_value_noise_height.sv */
// Channel  Dir  Payload                        Handshake
// in_if    in   pixel_x, pixel_y               valid/ready
// out_if   out  height_value, saturated        valid/ready
// cfg_if   in   index, data                    valid/ready (ready always high)
//
// One pixel per cycle while the output buffer is not full; each octave is a
// ten-stage cell (hash multiplier chain plus lerp and weighting multipliers).
// Synchronous active-low reset clears the pipeline valids, the output buffer
// and restores the register defaults.
// A two-entry output buffer takes results while the sink stalls; the cell
// chain holds only when both entries are full.
`default_nettype none

module fractal_value_noise_height #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_BITS  = fvn_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  fvn_in_if.sink           in_if,
  fvn_out_if.source        out_if,
  fvn_cfg_if.sink          cfg_if
);
  import fvn_pkg::*;

  localparam int CB = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam logic [PIX_W-1:0] CMASK = PIX_W'((1 << CB) - 1);

  typedef struct packed {
    logic [31:0] acc;
    logic        flag;
  } res_t;

  logic [CNT_W-1:0]  octave_count_r;
  logic [FREQ_W-1:0] base_frequency_r;
  logic [AMP_W-1:0]  base_amplitude_r;
  logic [LAC_W-1:0]  lacunarity_r;
  logic [PERS_W-1:0] persistence_r;

  ctl_t              ctl;
  logic              en;
  lane_t             lane_w [MAX_OCTAVES+1];
  logic [MAX_OCTAVES:0] vld_w;

  res_t              hd_r, tl_r, res_new;
  logic [1:0]        cnt_r;
  logic              push, pop;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r   <= RST_OCTAVES;
      base_frequency_r <= RST_FREQ;
      base_amplitude_r <= RST_AMP;
      lacunarity_r     <= RST_LAC;
      persistence_r    <= RST_PERS;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_OCTAVES: octave_count_r   <= cfg_if.data[CNT_W-1:0];
        REG_FREQ:    base_frequency_r <= cfg_if.data[FREQ_W-1:0];
        REG_AMP:     base_amplitude_r <= cfg_if.data[AMP_W-1:0];
        REG_LAC:     lacunarity_r     <= cfg_if.data[LAC_W-1:0];
        REG_PERS:    persistence_r    <= cfg_if.data[PERS_W-1:0];
        default: ;
      endcase
    end
  end

  assign en           = (cnt_r != 2'd2);
  assign in_if.ready  = en;

  assign ctl.en          = en;
  assign ctl.count       = (int'(octave_count_r) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES)
                                                                 : octave_count_r;
  assign ctl.lacunarity  = lacunarity_r;
  assign ctl.persistence = persistence_r;

  assign vld_w[0]       = in_if.valid;
  assign lane_w[0].x    = in_if.pixel_x & CMASK;
  assign lane_w[0].y    = in_if.pixel_y & CMASK;
  assign lane_w[0].freq = base_frequency_r;
  assign lane_w[0].amp  = base_amplitude_r;
  assign lane_w[0].acc  = '0;
  assign lane_w[0].flag = 1'b0;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    fvn_cell #(.OCT(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .in_vld  (vld_w[g]),
      .in_lane (lane_w[g]),
      .out_vld (vld_w[g+1]),
      .out_lane(lane_w[g+1])
    );
  end

  assign res_new = '{acc: lane_w[MAX_OCTAVES].acc, flag: lane_w[MAX_OCTAVES].flag};
  assign push    = en && vld_w[MAX_OCTAVES];
  assign pop     = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        hd_r <= res_new;
      end else begin
        hd_r <= tl_r;
        tl_r <= res_new;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        hd_r <= res_new;
      end else begin
        tl_r <= res_new;
      end
    end else if (pop) begin
      hd_r <= tl_r;
    end
  end

  assign out_if.valid        = (cnt_r != 2'd0);
  assign out_if.height_value = $signed(hd_r.acc);
  assign out_if.saturated    = hd_r.flag;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");
  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("buffer count did not grow on transfer in");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("buffer count did not shrink on transfer out");
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_w[MAX_OCTAVES]) && $stable(lane_w[MAX_OCTAVES]))
    else $error("cell chain moved while held");

endmodule

`default_nettype wire

/* design/fvn_hash.sv */
`default_nettype none

module fvn_hash (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        seed,
  output logic signed [17:0] corner
);
  import fvn_pkg::*;

  logic [31:0]        n2;
  logic [31:0]        n2_r, sq_r, n2b_r, m_r, v;
  logic signed [17:0] corner_r;

  assign n2 = (seed << 13) ^ seed;
  assign v  = n2b_r * m_r + HASH_A2;

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r     <= n2;
      sq_r     <= n2 * n2;
      n2b_r    <= n2_r;
      m_r      <= sq_r * HASH_M1 + HASH_A1;
      corner_r <= 18'sd65536 - $signed({1'b0, v[30:14]});
    end
  end

  assign corner = corner_r;

endmodule

`default_nettype wire

/* design/fvn_cell.sv */
`default_nettype none

module fvn_cell #(
  parameter int OCT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fvn_pkg::ctl_t  ctl,
  input  logic          in_vld,
  input  fvn_pkg::lane_t in_lane,
  output logic          out_vld,
  output fvn_pkg::lane_t out_lane
);
  import fvn_pkg::*;

  localparam int LAT = CELL_LAT;
  localparam int PW  = PIX_W + 32;

  typedef struct packed {
    lane_t       lane;
    logic [31:0] amp_nxt;
    logic        uflag;
    logic [15:0] sx;
    logic [15:0] sy;
  } carry_t;

  carry_t           c_r [LAT];
  carry_t           c1_nxt, c2_nxt, c9_nxt;
  logic [LAT-1:0]   v_r;

  logic             act, more;

  // stage A
  logic [PW-1:0]      fx_r, fy_r;
  logic [51:0]        fl_r;
  logic signed [49:0] ap_r, amp_x, pers_x;
  // stage B
  logic [31:0]        hx_r, hy_r, ttx_r, tty_r;
  logic [15:0]        tx_r, ty_r;
  logic [35:0]        fq;
  logic               fsat;
  logic [32:0]        asat;
  // stage C
  logic [31:0]        hx1, hy1;
  logic [17:0]        wx, wy;
  logic [49:0]        px, py;
  logic signed [17:0] ca, cb, cc, cd;
  // stages F to J
  logic signed [18:0] dab, dcd;
  logic signed [35:0] d1_r, d2_r;
  logic signed [17:0] ca_r, cc_r;
  logic signed [19:0] tsum, bsum, dtb, nsum;
  logic signed [18:0] top_g_r, bot_g_r, top_h_r;
  logic signed [36:0] pr_r;
  logic signed [51:0] wn_r;
  logic signed [35:0] asum;
  logic [32:0]        accs;

  assign act  = OCT < int'(ctl.count);
  assign more = (OCT + 1) < int'(ctl.count);

  assign amp_x  = 50'($signed(in_lane.amp));
  assign pers_x = $signed(50'({1'b0, ctl.persistence}));

  assign fq   = fl_r[51:16];
  assign fsat = |fq[35:32];
  assign asat = sat32(36'($signed(ap_r[49:16])));

  assign hx1 = hx_r + HASH_KX;
  assign hy1 = hy_r + HASH_KY;
  assign wx  = SMOOTH_3 - {1'b0, tx_r, 1'b0};
  assign wy  = SMOOTH_3 - {1'b0, ty_r, 1'b0};
  assign px  = 50'(ttx_r) * 50'(wx);
  assign py  = 50'(tty_r) * 50'(wy);

  fvn_hash u_ha (.clk(clk), .en(ctl.en), .seed(hx_r ^ hy_r), .corner(ca));
  fvn_hash u_hb (.clk(clk), .en(ctl.en), .seed(hx1 ^ hy_r),  .corner(cb));
  fvn_hash u_hc (.clk(clk), .en(ctl.en), .seed(hx_r ^ hy1),  .corner(cc));
  fvn_hash u_hd (.clk(clk), .en(ctl.en), .seed(hx1 ^ hy1),   .corner(cd));

  assign dab  = 19'(cb) - 19'(ca);
  assign dcd  = 19'(cd) - 19'(cc);
  assign tsum = 20'(ca_r) + 20'(d1_r[35:16]);
  assign bsum = 20'(cc_r) + 20'(d2_r[35:16]);
  assign dtb  = 20'(bot_g_r) - 20'(top_g_r);
  assign nsum = 20'(top_h_r) + 20'(pr_r[35:16]);
  assign asum = 36'($signed(c_r[8].lane.acc)) + 36'(wn_r[51:16]);
  assign accs = sat32(asum);

  always_comb begin
    c1_nxt            = c_r[0];
    c1_nxt.lane.freq  = fsat ? 32'hffffffff : fq[31:0];
    c1_nxt.amp_nxt    = asat[31:0];
    c1_nxt.uflag      = more && (fsat || asat[32]);
    c2_nxt            = c_r[1];
    c2_nxt.sx         = px[47:32];
    c2_nxt.sy         = py[47:32];
    c9_nxt            = c_r[8];
    c9_nxt.lane.amp   = c_r[8].amp_nxt;
    if (act) begin
      c9_nxt.lane.acc  = accs[31:0];
      c9_nxt.lane.flag = c_r[8].lane.flag | accs[32] | c_r[8].uflag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl.en) begin
      v_r <= {v_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      fx_r <= PW'(in_lane.x) * PW'(in_lane.freq);
      fy_r <= PW'(in_lane.y) * PW'(in_lane.freq);
      fl_r <= 52'(in_lane.freq) * 52'(ctl.lacunarity);
      ap_r <= amp_x * pers_x;

      hx_r  <= 32'(fx_r[PW-1:24]) * HASH_KX;
      hy_r  <= 32'(fy_r[PW-1:24]) * HASH_KY;
      tx_r  <= fx_r[23:8];
      ty_r  <= fy_r[23:8];
      ttx_r <= 32'(fx_r[23:8]) * 32'(fx_r[23:8]);
      tty_r <= 32'(fy_r[23:8]) * 32'(fy_r[23:8]);

      d1_r <= 36'(dab) * $signed(36'({1'b0, c_r[4].sx}));
      d2_r <= 36'(dcd) * $signed(36'({1'b0, c_r[4].sx}));
      ca_r <= ca;
      cc_r <= cc;

      top_g_r <= tsum[18:0];
      bot_g_r <= bsum[18:0];

      pr_r    <= 37'(dtb) * $signed(37'({1'b0, c_r[6].sy}));
      top_h_r <= top_g_r;

      wn_r <= 52'(nsum) * 52'($signed(c_r[7].lane.amp));

      c_r[0] <= '{lane: in_lane, amp_nxt: '0, uflag: 1'b0, sx: '0, sy: '0};
      c_r[1] <= c1_nxt;
      c_r[2] <= c2_nxt;
      for (int i = 3; i < LAT - 1; i++) begin
        c_r[i] <= c_r[i-1];
      end
      c_r[9] <= c9_nxt;
    end
  end

  assign out_vld  = v_r[LAT-1];
  assign out_lane = c_r[LAT-1].lane;

endmodule

`default_nettype wire

/* tb/sv/fractal_value_noise_height_test.sv */
`default_nettype none

module fractal_value_noise_height_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fvn_pkg::*;

  localparam int NUM_OCT   = MAX_OCTAVES_DEF;
  localparam int PIPE_LAT  = CELL_LAT * NUM_OCT + 1;
  localparam int STALL_MAX = 20000;

  typedef struct {
    logic signed [31:0] height;
    bit                 clip;
  } height_t;

  logic clk;
  logic rst_n;

  fvn_in_if  in_ch ();
  fvn_out_if out_ch ();
  fvn_cfg_if cfg_ch ();

  fractal_value_noise_height dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  // shadow registers
  logic [CNT_W-1:0]  m_octaves;
  logic [FREQ_W-1:0] m_freq;
  logic [AMP_W-1:0]  m_amp;
  logic [LAC_W-1:0]  m_lac;
  logic [PERS_W-1:0] m_pers;

  height_t heights_due[$];
  int      errors;
  int      hold_left;
  bit      no_idle;
  int      idle_cycles;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint clip32(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint corner_val(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] n;
    logic [31:0] v;
    n = (cx * HASH_KX) ^ (cy * HASH_KY);
    n = (n << 13) ^ n;
    v = (n * (n * n * HASH_M1 + HASH_A1) + HASH_A2) & 32'h7fffffff;
    return 64'sd65536 - longint'({32'd0, v >> 14});
  endfunction

  function automatic longint fade(longint t);
    return (t * t * (64'sd196608 - 2 * t)) >>> 32;
  endfunction

  function automatic longint blend(longint a, longint b, longint s);
    return a + (((b - a) * s) >>> 16);
  endfunction

  function automatic longint value_noise(longint x, longint y, longint f);
    longint      fx;
    longint      fy;
    logic [31:0] cx;
    logic [31:0] cy;
    longint      sx;
    longint      sy;
    fx = x * f;
    fy = y * f;
    cx = fx[55:24];
    cy = fy[55:24];
    sx = fade((fx >> 8) & 64'hffff);
    sy = fade((fy >> 8) & 64'hffff);
    return blend(blend(corner_val(cx, cy), corner_val(cx + 1, cy), sx),
                 blend(corner_val(cx, cy + 1), corner_val(cx + 1, cy + 1), sx), sy);
  endfunction

  function automatic height_t fbm_height(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    height_t h;
    int      cnt;
    longint  f;
    longint  a;
    longint  acc;
    bit      flag;
    cnt  = (m_octaves > NUM_OCT) ? NUM_OCT : int'(m_octaves);
    f    = longint'({32'd0, m_freq});
    a    = longint'(signed'(m_amp));
    acc  = 0;
    flag = 1'b0;
    for (int o = 0; o < cnt; o++) begin
      acc = clip32(acc + ((value_noise(longint'({52'd0, px}), longint'({52'd0, py}), f)
                           * a) >>> 16), flag);
      if (o + 1 < cnt) begin
        f = (f * longint'({44'd0, m_lac})) >> 16;
        if (f > 64'sd4294967295) begin
          f    = 64'sd4294967295;
          flag = 1'b1;
        end
        a = clip32((a * longint'({47'd0, m_pers})) >>> 16, flag);
      end
    end
    h.height = acc[31:0];
    h.clip   = flag;
    return h;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    height_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (heights_due.size() == 0) begin
        report("unexpected transfer, height", 64'sd0, longint'(out_ch.height_value));
      end else begin
        e = heights_due.pop_front();
        if (out_ch.height_value !== e.height) begin
          report("height_value", longint'(e.height), longint'(out_ch.height_value));
        end
        if (out_ch.saturated !== e.clip) begin
          report("saturated", longint'({63'd0, e.clip}), longint'({63'd0, out_ch.saturated}));
        end
      end
    end
  end

  // receiver: runs and gaps, plus forced hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= (pick_gap() == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    int gap;
    height_t h;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    h = fbm_height(px, py);
    in_ch.valid   <= 1'b1;
    in_ch.pixel_x <= px;
    in_ch.pixel_y <= py;
    do @(posedge clk); while (!in_ch.ready);
    heights_due.push_back(h);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (heights_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_OCTAVES: m_octaves = d[CNT_W-1:0];
      REG_FREQ:    m_freq    = d[FREQ_W-1:0];
      REG_AMP:     m_amp     = d[AMP_W-1:0];
      REG_LAC:     m_lac     = d[LAC_W-1:0];
      REG_PERS:    m_pers    = d[PERS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] oc, logic [31:0] f, logic [31:0] a,
                         logic [31:0] l, logic [31:0] p);
    wait_drained();
    set_reg(REG_OCTAVES, oc);
    set_reg(REG_FREQ, f);
    set_reg(REG_AMP, a);
    set_reg(REG_LAC, l);
    set_reg(REG_PERS, p);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd0, 12'hfff);
    send_pixel(12'hfff, 12'd0);
    send_pixel(12'h555, 12'haaa);
  endtask

  task automatic test_octave_limits();
    set_all(0, 32'h0100_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000);
    send_pixel(12'h123, 12'h456);
    set_all(8, 32'h0100_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000);
    send_pixel(12'h123, 12'h456);
    set_all(9, 32'h0100_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000);
    send_pixel(12'h123, 12'h456);
    set_all(15, 32'hffff_ffff, 32'h0001_0000, 32'd0, 32'd0);
    send_pixel(12'hfff, 12'h001);
  endtask

  task automatic test_saturation();
    // frequency clips
    set_all(8, 32'hffff_ffff, 32'h0001_0000, 32'h000f_ffff, 32'h0001_0000);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd7, 12'd3000);
    // amplitude and sum clip, both signs
    set_all(8, 32'h0123_4567, 32'h7fff_ffff, 32'h0001_0000, 32'h0001_ffff);
    send_pixel(12'd1, 12'd2);
    send_pixel(12'd900, 12'd17);
    set_all(8, 32'h0123_4567, 32'h8000_0000, 32'h0001_0000, 32'h0001_ffff);
    send_pixel(12'd1, 12'd2);
    send_pixel(12'd900, 12'd17);
    set_all(1, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
    send_pixel(12'd0, 12'd0);
  endtask

  task automatic test_backpressure();
    set_all(8, 32'h0003_3333, 32'h0002_0000, 32'h0001_c000, 32'h0000_c000);
    hold_left = 400;
    no_idle = 1'b1;
    for (int i = 0; i < 200; i++) send_pixel(PIX_W'($urandom), PIX_W'($urandom));
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_configs();
    logic [31:0] oc;
    logic [31:0] f;
    logic [31:0] a;
    for (int ph = 0; ph < 12; ph++) begin
      oc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      case ($urandom_range(0, 2))
        0: f = $urandom;
        1: f = $urandom_range(0, 32'h0400_0000);
        default: f = $urandom_range(0, 32'h0010_0000);
      endcase
      a = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      set_all(oc, f, a, $urandom, $urandom);
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < 122; i++) send_pixel(PIX_W'($urandom), PIX_W'($urandom));
      no_idle = 1'b0;
    end
  endtask

  initial begin
    errors       = 0;
    hold_left    = 0;
    no_idle      = 1'b0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_OCTAVES;
    cfg_ch.data  = '0;
    m_octaves = RST_OCTAVES;
    m_freq    = RST_FREQ;
    m_amp     = RST_AMP;
    m_lac     = RST_LAC;
    m_pers    = RST_PERS;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_octave_limits();
    test_saturation();
    test_backpressure();
    test_random_configs();
    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/fvn_pkg.sv
design/fvn_if.sv
design/fvn_hash.sv
design/fvn_cell.sv
design/fractal_value_noise_height.sv
tb/sv/fractal_value_noise_height_test.sv
